[hdl/plruc_pkg.sv]
// Shared types and constants for the pinned LRU slot cache.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package plruc_pkg;

  // default configuration
  localparam int WAYS_DEF        = 4;
  localparam int KEY_WIDTH_DEF   = 64;
  localparam int STAMP_WIDTH_DEF = 32;

  // fixed field widths of the stream words
  localparam int KEY_IN_W   = 64;
  localparam int PIN_W      = 4;
  localparam int SLOT_W     = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one lookup result, hit in the lowest bit
  typedef struct packed {
    logic              replaced_valid;
    logic              no_slot;
    logic [SLOT_W-1:0] slot;
    logic              hit;
  } plruc_result_t;

endpackage

[hdl/pinned_lru_slot_cache_top.sv]
// Top level of the pinned LRU slot cache: input stage, request queue and lookup engine.
// Depends on plruc_pkg, plruc_front, plruc_queue and plruc_back.
`timescale 1ns / 1ps

// Fully associative cache of WAYS entries with least-recently-used replacement.
// Each input word carries a key and a pin mask (bit i keeps way i from eviction);
// each request yields exactly one result word: hit and its way, or the way just
// filled and whether it evicted a valid entry, or no_slot when every way is
// valid and pinned. Every request advances a wrapping use counter that stamps
// the way it touches; stamps compare as plain unsigned values. While the
// receiver keeps out_tready high the block sustains one request per clock: the
// lookup engine does the tag compare, the age scan across all ways and the
// entry update together, so the next request sees the updated entries. A
// request passes the input register, the two-entry request queue and the
// result register. Only the low KEY_WIDTH bits of the key are stored and
// compared. No clearing pass is needed after reset.
module pinned_lru_slot_cache_top #(
  parameter int WAYS        = plruc_pkg::WAYS_DEF,
  parameter int KEY_WIDTH   = plruc_pkg::KEY_WIDTH_DEF,
  parameter int STAMP_WIDTH = plruc_pkg::STAMP_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] key, [67:64] pin_mask, [71:68] zero
  input  logic [plruc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] hit, [2:1] slot, [3] no_slot, [4] replaced_valid, [7:5] zero
  output logic [plruc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import plruc_pkg::*;

  localparam int REQ_W = KEY_WIDTH + PIN_W;

  logic             push_valid, push_ready;
  logic [REQ_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [REQ_W-1:0] pop_data;
  plruc_result_t    res;

  // accept and trim requests
  plruc_front #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  plruc_queue #(
    .DATA_W (REQ_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // lookup and replacement
  plruc_back #(
    .WAYS        (WAYS),
    .KEY_WIDTH   (KEY_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (pop_valid),
    .req_ready (pop_ready),
    .req_data  (pop_data),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // result word, zero padded
  assign out_tdata = OUT_DATA_W'(res);

endmodule

[hdl/plruc_front.sv]
// Input stage: takes request words, trims the key and hands requests to the queue.
// Depends on plruc_pkg.
`timescale 1ns / 1ps

module plruc_front #(
  parameter int KEY_WIDTH = plruc_pkg::KEY_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [plruc_pkg::IN_DATA_W-1:0]         in_tdata,
  output logic                                    push_valid,
  input  logic                                    push_ready,
  output logic [KEY_WIDTH+plruc_pkg::PIN_W-1:0]   push_data
);
  import plruc_pkg::*;

  localparam int REQ_W = KEY_WIDTH + PIN_W;

  logic             req_valid_r;
  logic [REQ_W-1:0] req_data_r;
  logic             accept;

  // stage is free when empty or draining into the queue this cycle
  assign in_tready = !req_valid_r || push_ready;
  assign accept    = in_tvalid && in_tready;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (accept) begin
      req_valid_r <= 1'b1;
    end else if (push_ready) begin
      req_valid_r <= 1'b0;
    end
  end

  // payload: pins above the kept low key bits
  always_ff @(posedge clk) begin
    if (accept) begin
      req_data_r <= {in_tdata[KEY_IN_W +: PIN_W], in_tdata[KEY_WIDTH-1:0]};
    end
  end

  assign push_valid = req_valid_r;
  assign push_data  = req_data_r;

endmodule

[hdl/plruc_queue.sv]
// Short request queue that decouples the input stage from the lookup engine.
// Depends on plruc_pkg for its depth.
`timescale 1ns / 1ps

module plruc_queue #(
  parameter int DATA_W = plruc_pkg::KEY_WIDTH_DEF + plruc_pkg::PIN_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import plruc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              push, pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[hdl/plruc_back.sv]
// Lookup engine: tag compare, LRU victim scan, entry update and result register.
// Depends on plruc_pkg.
`timescale 1ns / 1ps

module plruc_back #(
  parameter int WAYS        = plruc_pkg::WAYS_DEF,
  parameter int KEY_WIDTH   = plruc_pkg::KEY_WIDTH_DEF,
  parameter int STAMP_WIDTH = plruc_pkg::STAMP_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  logic [KEY_WIDTH+plruc_pkg::PIN_W-1:0] req_data,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output plruc_pkg::plruc_result_t              res
);
  import plruc_pkg::*;

  localparam int IDX_W = $clog2(WAYS);

  // entry state
  logic [WAYS-1:0]        valid_r;
  logic [KEY_WIDTH-1:0]   key_r   [WAYS];
  logic [STAMP_WIDTH-1:0] stamp_r [WAYS];
  logic [STAMP_WIDTH-1:0] counter_r;

  logic                   res_valid_r;
  plruc_result_t          res_r;

  logic [KEY_WIDTH-1:0]   req_key;
  logic [WAYS-1:0]        pins;
  logic [STAMP_WIDTH-1:0] counter_nxt;
  logic                   fire;

  logic                   hit_any;
  logic [IDX_W-1:0]       hit_idx;
  logic                   vic_found;
  logic [IDX_W-1:0]       vic_idx;
  logic [STAMP_WIDTH-1:0] vic_stamp;
  plruc_result_t          res_nxt;

  // request fields; pin bits beyond the way count drop out, missing ones read as zero
  assign req_key     = req_data[KEY_WIDTH-1:0];
  assign pins        = WAYS'(req_data[KEY_WIDTH +: PIN_W]);
  assign counter_nxt = counter_r + 1'b1;
  assign req_ready   = !res_valid_r || res_ready;
  assign fire        = req_valid && req_ready;

  // tag compare, lowest matching way wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == req_key)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // victim scan in way order: empty way always taken, else strictly older stamp
  always_comb begin
    logic [STAMP_WIDTH-1:0] eff_stamp;
    vic_found = 1'b0;
    vic_idx   = '0;
    vic_stamp = '0;
    for (int i = 0; i < WAYS; i++) begin
      eff_stamp = valid_r[i] ? stamp_r[i] : '0;
      if (!(valid_r[i] && pins[i])) begin
        if (!vic_found || !valid_r[i] || (eff_stamp < vic_stamp)) begin
          vic_found = 1'b1;
          vic_idx   = IDX_W'(i);
          vic_stamp = eff_stamp;
        end
      end
    end
  end

  // result word
  always_comb begin
    res_nxt = '0;
    if (hit_any) begin
      res_nxt.hit  = 1'b1;
      res_nxt.slot = SLOT_W'(hit_idx);
    end else if (vic_found) begin
      res_nxt.slot           = SLOT_W'(vic_idx);
      res_nxt.replaced_valid = valid_r[vic_idx];
    end else begin
      res_nxt.no_slot = 1'b1;
    end
  end

  // control state: valid bits, use counter, result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      counter_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        counter_r   <= counter_nxt;
        res_valid_r <= 1'b1;
        if (!hit_any && vic_found) begin
          valid_r[vic_idx] <= 1'b1;
        end
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // entry payload and result register
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
      if (hit_any) begin
        stamp_r[hit_idx] <= counter_nxt;
      end else if (vic_found) begin
        key_r[vic_idx]   <= req_key;
        stamp_r[vic_idx] <= counter_nxt;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  // a result never claims both a hit and a full cache
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> !(res_r.hit && res_r.no_slot))
    else $error("hit and no_slot both set");

  // every processed request advances the use counter by one
  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (counter_r == $past(counter_nxt)))
    else $error("use counter did not advance");

  // once filled, an entry stays valid
  a_valid_keep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((valid_r & $past(valid_r)) == $past(valid_r)))
    else $error("valid entry was dropped");

  // counter moves only when a request is processed
  a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!fire && $past(rst_n)) |=> $stable(counter_r))
    else $error("use counter moved without a request");
`endif

endmodule

[test/tb_pinned_lru_slot_cache_top.sv]
// Testbench for pinned_lru_slot_cache_top: directed and random lookups checked against
// an in-bench LRU cache predictor, with random stalls on both stream sides.
// Depends on plruc_pkg and the pinned_lru_slot_cache_top RTL.
`timescale 1ns / 1ps

module tb_pinned_lru_slot_cache_top;
  import plruc_pkg::*;

  localparam int NUM_WAYS   = WAYS_DEF;
  localparam int STUCK_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [63:0] key, [67:64] pin_mask, [71:68] zero
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] hit, [2:1] slot, [3] no_slot, [4] replaced_valid, [7:5] zero
  logic [OUT_DATA_W-1:0] out_tdata;

  // predicted cache contents
  logic                 way_valid [NUM_WAYS];
  logic [KEY_IN_W-1:0]  way_key   [NUM_WAYS];
  logic [31:0]          way_stamp [NUM_WAYS];
  logic [31:0]          use_count;

  plruc_result_t pending_results[$];
  int            error_count = 0;
  int            stuck_cycles = 0;
  int            ready_hold = 0;
  bit            send_gaps_on = 1'b1;
  bit            ready_stalls_on = 1'b1;

  // key pool for working-set traffic
  logic [KEY_IN_W-1:0] key_pool[16];

  pinned_lru_slot_cache_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // lookup against the predicted contents, then update them like the cache does
  function automatic plruc_result_t lookup_way(logic [KEY_IN_W-1:0] key, logic [PIN_W-1:0] pins);
    plruc_result_t res;
    int            victim;
    bit            found;
    victim = -1;
    found  = 1'b0;
    res    = '0;
    use_count = use_count + 32'd1;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!found) begin
        if (way_valid[i] && way_key[i] == key) begin
          way_stamp[i] = use_count;
          res.hit  = 1'b1;
          res.slot = SLOT_W'(i);
          found    = 1'b1;
        end else if (!(way_valid[i] && pins[i])) begin
          // empty ways always take over; valid ones only when strictly older
          if (victim < 0 || !way_valid[i] || way_stamp[i] < way_stamp[victim])
            victim = i;
        end
      end
    end
    if (!found) begin
      if (victim < 0) begin
        res.no_slot = 1'b1;
      end else begin
        res.slot           = SLOT_W'(victim);
        res.replaced_valid = way_valid[victim];
        way_valid[victim]  = 1'b1;
        way_key[victim]    = key;
        way_stamp[victim]  = use_count;
      end
    end
    return res;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // pin mask biased toward few pins, with full pinning now and then
  function automatic logic [PIN_W-1:0] pick_pins();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return '0;
    else if (r < 7) return PIN_W'($urandom);
    else if (r < 8) return '1;
    else return ~(PIN_W'(1) << $urandom_range(0, PIN_W - 1));
  endfunction

  function automatic logic [KEY_IN_W-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // pool: random keys at even slots, keys one bit off a random base at odd slots
  task automatic refill_pool(int pool_size);
    logic [KEY_IN_W-1:0] base;
    base = random_key();
    for (int i = 0; i < pool_size; i++) begin
      if (i % 2 == 0) key_pool[i] = random_key();
      else key_pool[i] = base ^ (KEY_IN_W'(1) << $urandom_range(0, KEY_IN_W - 1));
    end
  endtask

  // send one request word and record its expected result on acceptance
  task automatic send_request(logic [KEY_IN_W-1:0] key, logic [PIN_W-1:0] pins);
    int gap;
    in_tdata  <= {{(IN_DATA_W - KEY_IN_W - PIN_W){1'b0}}, pins, key};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(lookup_way(key, pins));
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // fill from empty, pins on empty ways, pinned hits, full pinning, LRU eviction
  task automatic test_directed();
    send_request(64'h0, 4'h0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
    send_request(64'h0, 4'hF);
    send_request(64'h5555_5555_5555_5555, 4'h0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 4'b1000);
    send_request(64'h0123_4567_89AB_CDEF, 4'hF);
    send_request(64'h0123_4567_89AB_CDEF, 4'b0111);
    send_request(64'h8000_0000_0000_0000, 4'h0);
    send_request(64'h1, 4'h0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 4'b0001);
    send_request(64'h8000_0000_0000_0000, 4'h0);
    send_request(64'h1, 4'b0010);
    send_request(64'h0123_4567_89AB_CDEF, 4'h0);
    send_request(64'h2, 4'b1110);
    send_request(64'h7FFF_FFFF_FFFF_FFFF, 4'b1101);
    send_request(64'hFFFF_FFFF_FFFF_FFFE, 4'hF);
  endtask

  // mostly pooled keys so hits, evictions and no-slot all recur
  task automatic run_pool_traffic(int count, int pool_size, int pool_pct);
    logic [KEY_IN_W-1:0] key;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) refill_pool(pool_size);
      if ($urandom_range(0, 99) < pool_pct) key = key_pool[$urandom_range(0, pool_size - 1)];
      else key = random_key();
      send_request(key, pick_pins());
    end
  endtask

  task automatic test_working_set();
    send_gaps_on    = 1'b1;
    ready_stalls_on = 1'b1;
    run_pool_traffic(1400, 6, 85);
  endtask

  task automatic test_back_to_back();
    send_gaps_on    = 1'b0;
    ready_stalls_on = 1'b0;
    run_pool_traffic(250, 5, 90);
  endtask

  task automatic test_scattered_keys();
    send_gaps_on    = 1'b1;
    ready_stalls_on = 1'b1;
    run_pool_traffic(280, 16, 50);
  endtask

  // receiver: runs of ready broken by random stalls
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!ready_stalls_on || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    plruc_result_t got;
    plruc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = plruc_result_t'(out_tdata[$bits(plruc_result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit != want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          error_count++;
        end
        if (got.slot != want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          error_count++;
        end
        if (got.no_slot != want.no_slot) begin
          $error("no_slot: expected %0d, got %0d", want.no_slot, got.no_slot);
          error_count++;
        end
        if (got.replaced_valid != want.replaced_valid) begin
          $error("replaced_valid: expected %0d, got %0d", want.replaced_valid,
                 got.replaced_valid);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      way_valid[i] = 1'b0;
      way_key[i]   = '0;
      way_stamp[i] = '0;
    end
    use_count = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_working_set();
    test_back_to_back();
    test_scattered_keys();
    in_tvalid <= 1'b0;

    // drain, then allow for the pipeline latency
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
